FILE: sv/cfc_pkg.sv
`timescale 1ns / 1ps

package cfc_pkg;

    localparam int unsigned CountWidth = 7;
    localparam int unsigned PortWidth  = 16;
    localparam int unsigned HdrWidth   = 6;
    localparam int unsigned KindWidth  = 2;

    localparam logic [CountWidth-1:0] CountMax   = 7'd127;
    localparam logic [CountWidth-1:0] IdxTypeHi  = 7'd12;
    localparam logic [CountWidth-1:0] IdxTypeLo  = 7'd13;
    localparam logic [CountWidth-1:0] IdxHdrLen  = 7'd14;
    localparam logic [CountWidth-1:0] IdxProto   = 7'd23;
    localparam logic [CountWidth-1:0] PortOffHi  = 7'd16;
    localparam logic [CountWidth-1:0] PortOffLo  = 7'd17;
    localparam logic [CountWidth-1:0] EthMinLen  = 7'd14;
    localparam logic [CountWidth-1:0] Ipv4MinLen = 7'd34;
    localparam logic [CountWidth-1:0] UdpOffLen  = 7'd22;
    localparam logic [HdrWidth-1:0]   HdrMin     = 6'd20;

    localparam logic [15:0] EthTypeIpv4 = 16'h0800;
    localparam logic [15:0] EthTypeArp  = 16'h0806;
    localparam logic [7:0]  ProtoUdp    = 8'd17;
    localparam logic [PortWidth-1:0] PortReset = 16'd5002;

    localparam logic [KindWidth-1:0] KindNone = 2'd0;
    localparam logic [KindWidth-1:0] KindArp  = 2'd1;
    localparam logic [KindWidth-1:0] KindUdp  = 2'd2;

endpackage

FILE: sv/control_frame_classifier_top.sv
`timescale 1ns / 1ps

// Control frame classifier.
// Input channel: one frame byte per request (i_frame_byte, i_last_byte),
// handshake i_in_valid / o_in_stall. Bytes start at the destination address.
// Output channel: one verdict per frame (o_keep_frame, o_match_kind),
// handshake o_out_valid / i_out_stall. ARP frames of 14 bytes or more give
// kind 1; IPv4/UDP frames to the configured port with a sane header give
// kind 2; everything else gives kind 0 with keep low.
// Throughput is one byte per cycle while the input is not stalled. The
// verdict appears in the output register in the cycle after the last byte
// is accepted. Field capture and the verdict are one level of compares
// between the frame state registers and the output register.
// While a verdict waits with i_out_stall high, the input is stalled too and
// the waiting verdict holds; once taken, a new one may load the same cycle.
// i_cfg_wr_en writes the UDP port register from i_cfg_wr_data; write it only
// between frames. Synchronous reset clears the frame state and output valid
// and loads port 5002.
module control_frame_classifier_top
    import cfc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [PortWidth-1:0] i_cfg_wr_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [7:0]           i_frame_byte,
    input  logic                 i_last_byte,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic                 o_keep_frame,
    output logic [KindWidth-1:0] o_match_kind
);

    logic [PortWidth-1:0]  r_ctrl_port;
    logic [CountWidth-1:0] r_byte_count, n_byte_count;
    logic [15:0]           r_ether_type, n_ether_type;
    logic [HdrWidth-1:0]   r_hdr_bytes, n_hdr_bytes;
    logic                  r_udp_seen, n_udp_seen;
    logic [PortWidth-1:0]  r_dest_port, n_dest_port;
    logic                  r_out_valid;
    logic [KindWidth-1:0]  r_kind, n_kind;

    logic                  in_accept;
    logic                  out_load;
    logic [CountWidth-1:0] len;
    logic [CountWidth-1:0] hdr_ext;

    assign o_in_stall  = r_out_valid & i_out_stall;
    assign in_accept   = i_in_valid & ~o_in_stall;
    assign out_load    = in_accept & i_last_byte;
    assign hdr_ext     = {1'b0, r_hdr_bytes};
    assign len         = (r_byte_count < CountMax) ? r_byte_count + 7'd1 : CountMax;

    always_comb begin
        n_byte_count = len;
        n_ether_type = r_ether_type;
        n_hdr_bytes  = r_hdr_bytes;
        n_udp_seen   = r_udp_seen;
        n_dest_port  = r_dest_port;

        if (r_byte_count == IdxTypeHi) begin
            n_ether_type[15:8] = i_frame_byte;
        end
        if (r_byte_count == IdxTypeLo) begin
            n_ether_type[7:0] = i_frame_byte;
        end
        if (r_byte_count == IdxHdrLen) begin
            n_hdr_bytes = {i_frame_byte[3:0], 2'b00};
        end
        if (r_byte_count == IdxProto) begin
            n_udp_seen = (i_frame_byte == ProtoUdp);
        end
        if (r_byte_count > IdxHdrLen) begin
            if (r_byte_count == PortOffHi + hdr_ext) begin
                n_dest_port[15:8] = i_frame_byte;
            end
            if (r_byte_count == PortOffLo + hdr_ext) begin
                n_dest_port[7:0] = i_frame_byte;
            end
        end
    end

    // Verdict from the state as it stands after this byte is captured.
    always_comb begin
        priority if (len < EthMinLen) begin
            n_kind = KindNone;
        end else if (n_ether_type == EthTypeArp) begin
            n_kind = KindArp;
        end else if (n_ether_type != EthTypeIpv4 || len < Ipv4MinLen) begin
            n_kind = KindNone;
        end else if (n_hdr_bytes < HdrMin || len < UdpOffLen + {1'b0, n_hdr_bytes}
                     || !n_udp_seen) begin
            n_kind = KindNone;
        end else if (n_dest_port == r_ctrl_port) begin
            n_kind = KindUdp;
        end else begin
            n_kind = KindNone;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl_port <= PortReset;
        end else if (i_cfg_wr_en) begin
            r_ctrl_port <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count <= '0;
            r_ether_type <= '0;
            r_hdr_bytes  <= '0;
            r_udp_seen   <= 1'b0;
            r_dest_port  <= '0;
        end else if (in_accept) begin
            if (i_last_byte) begin
                // clear for the next frame
                r_byte_count <= '0;
                r_ether_type <= '0;
                r_hdr_bytes  <= '0;
                r_udp_seen   <= 1'b0;
                r_dest_port  <= '0;
            end else begin
                r_byte_count <= n_byte_count;
                r_ether_type <= n_ether_type;
                r_hdr_bytes  <= n_hdr_bytes;
                r_udp_seen   <= n_udp_seen;
                r_dest_port  <= n_dest_port;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_kind <= n_kind;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_match_kind = r_kind;
    assign o_keep_frame = (r_kind != KindNone);

endmodule

FILE: sim/tb_control_frame_classifier_top.sv
`timescale 1ns / 1ps

module tb_control_frame_classifier_top;
    import cfc_pkg::*;

    localparam int CycleLimit = 200000;
    localparam int IdlePct    = 23;

    typedef struct packed {
        logic                 keep;
        logic [KindWidth-1:0] kind;
    } t_verdict;

    typedef logic [7:0] t_octet_q[$];

    // Frame state tracker and store of verdicts owed by the block.
    class frame_verdict_board;
        logic [PortWidth-1:0]  port;
        logic [CountWidth-1:0] count;
        logic [15:0]           ether_type;
        logic [HdrWidth-1:0]   hdr_bytes;
        logic                  udp_seen;
        logic [PortWidth-1:0]  udp_dport;
        t_verdict              verdicts_due[$];
        int                    errors;

        function new();
            port   = PortReset;
            errors = 0;
            clear_frame();
        endfunction

        function void clear_frame();
            count      = '0;
            ether_type = '0;
            hdr_bytes  = '0;
            udp_seen   = 1'b0;
            udp_dport  = '0;
        endfunction

        function logic [KindWidth-1:0] classify(int len);
            if (len < 14) return KindNone;
            if (ether_type == EthTypeArp) return KindArp;
            if (ether_type != EthTypeIpv4 || len < 34) return KindNone;
            if (hdr_bytes < 20 || len < 22 + hdr_bytes || !udp_seen) return KindNone;
            return (udp_dport == port) ? KindUdp : KindNone;
        endfunction

        function void note_request(logic [7:0] b, logic last);
            int                   idx;
            int                   len;
            logic [KindWidth-1:0] kind;
            idx = count;
            if (idx == 12) begin
                ether_type[15:8] = b;
            end else if (idx == 13) begin
                ether_type[7:0] = b;
            end else if (idx == 14) begin
                hdr_bytes = {b[3:0], 2'b00};
            end
            if (idx == 23) udp_seen = (b == ProtoUdp);
            // port position follows the header length seen so far
            if (idx > 14) begin
                if (idx == 16 + hdr_bytes) begin
                    udp_dport[15:8] = b;
                end else if (idx == 17 + hdr_bytes) begin
                    udp_dport[7:0] = b;
                end
            end
            len   = (idx < 127) ? idx + 1 : 127;
            count = CountWidth'(len);
            if (last) begin
                kind = classify(len);
                verdicts_due.push_back({kind != KindNone, kind});
                clear_frame();
            end
        endfunction

        task report_mismatch(string msg);
            $display("ERROR: %s", msg);
            errors++;
        endtask

        task check_verdict(logic keep, logic [KindWidth-1:0] kind);
            t_verdict want;
            if (verdicts_due.size() == 0) begin
                report_mismatch($sformatf("verdict keep=%0b kind=%0d with no frame pending",
                                          keep, kind));
                return;
            end
            want = verdicts_due.pop_front();
            if (keep !== want.keep)
                report_mismatch($sformatf("keep_frame %0b, want %0b", keep, want.keep));
            if (kind !== want.kind)
                report_mismatch($sformatf("match_kind %0d, want %0d", kind, want.kind));
        endtask
    endclass

    logic                 clk           = 1'b0;
    logic                 rst_n         = 1'b0;
    logic                 cfg_wr_en     = 1'b0;
    logic [PortWidth-1:0] cfg_wr_data   = '0;
    logic                 in_valid      = 1'b0;
    logic                 in_stall;
    logic [7:0]           frame_byte    = '0;
    logic                 last_byte     = 1'b0;
    logic                 out_valid;
    logic                 out_stall     = 1'b0;
    logic                 keep_frame;
    logic [KindWidth-1:0] match_kind;

    frame_verdict_board sb;
    int                 cycles      = 0;
    int                 frames_sent = 0;
    bit                 steady      = 1'b0;

    control_frame_classifier_top u_top (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_frame_byte  (frame_byte),
        .i_last_byte   (last_byte),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_keep_frame  (keep_frame),
        .o_match_kind  (match_kind)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CycleLimit) begin
            $display("FAIL control_frame_classifier_top");
            $finish;
        end
    end

    always @(negedge clk) begin
        out_stall <= !steady && ($urandom_range(0, 99) < IdlePct);
    end

    always @(posedge clk) begin
        if (rst_n && out_valid === 1'b1 && !out_stall)
            sb.check_verdict(keep_frame, match_kind);
    end

    // Enter and leave at a falling edge.
    task automatic send_byte(logic [7:0] b, logic last);
        while (!steady && $urandom_range(0, 99) < IdlePct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        frame_byte <= b;
        last_byte  <= last;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_request(b, last);
        @(negedge clk);
    endtask

    task automatic send_frame(t_octet_q fb);
        for (int i = 0; i < fb.size(); i++)
            send_byte(fb[i], i == fb.size() - 1);
        frames_sent++;
        // hold a long stretch with no gaps on either side
        steady = (frames_sent >= 20 && frames_sent < 30);
    endtask

    function automatic t_octet_q random_frame(logic [PortWidth-1:0] port);
        int             pick;
        int             len;
        int             nib;
        int             hdr;
        int             floor_len;
        logic [15:0]    etype;
        logic [15:0]    dport;
        logic [7:0]     proto;
        t_octet_q       fb;
        pick      = $urandom_range(0, 99);
        nib       = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4) : $urandom_range(5, 15);
        hdr       = nib * 4;
        floor_len = (22 + hdr > 34) ? 22 + hdr : 34;
        proto     = ($urandom_range(0, 9) == 0) ? 8'($urandom) : ProtoUdp;
        dport     = ($urandom_range(0, 3) == 0) ? 16'($urandom) : port;
        etype     = EthTypeIpv4;
        if (pick < 55) begin
            len = floor_len + $urandom_range(0, 8);
        end else if (pick < 70) begin
            etype = EthTypeArp;
            len   = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 13) : $urandom_range(14, 60);
        end else if (pick < 85) begin
            etype = 16'($urandom);
            len   = $urandom_range(1, 40);
        end else if (pick < 93) begin
            // long frames, many long enough to saturate the byte counter
            len = $urandom_range(100, 140);
            if (pick[0]) etype = EthTypeArp;
        end else begin
            // near misses: one byte short, or one type bit flipped
            len = floor_len;
            if ($urandom_range(0, 1)) len = len - 1;
            else etype = etype ^ (16'h1 << $urandom_range(0, 15));
        end
        for (int i = 0; i < len; i++) fb.push_back(8'($urandom));
        if (len > 12) fb[12] = etype[15:8];
        if (len > 13) fb[13] = etype[7:0];
        if (len > 14) fb[14] = {4'($urandom), 4'(nib)};
        if (len > 23) fb[23] = proto;
        if (len > 16 + hdr) fb[16 + hdr] = dport[15:8];
        if (len > 17 + hdr) fb[17 + hdr] = dport[7:0];
        return fb;
    endfunction

    task automatic run_random();
        int bytes_sent;
        int frames;
        t_octet_q fb;
        bytes_sent = 0;
        frames     = 0;
        while (bytes_sent < 175 || frames < 12) begin
            fb = random_frame(sb.port);
            send_frame(fb);
            bytes_sent += fb.size();
            frames++;
        end
    endtask

    // Drop valid and let every owed verdict drain.
    task automatic settle();
        in_valid <= 1'b0;
        while (sb.verdicts_due.size() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_port(logic [PortWidth-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        sb.port      = value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    initial begin
        t_octet_q fb;
        sb = new();
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // one-byte frame
        fb = '{8'h00};
        send_frame(fb);
        // ARP type but one byte too short
        fb = {};
        for (int i = 0; i < 13; i++) fb.push_back(8'hff);
        fb[12] = EthTypeArp[15:8];
        send_frame(fb);
        // shortest ARP frame that is kept
        fb = {};
        for (int i = 0; i < 14; i++) fb.push_back(8'h00);
        fb[12] = EthTypeArp[15:8];
        fb[13] = EthTypeArp[7:0];
        send_frame(fb);

        run_random();
        settle();
        write_port(16'h0000);
        run_random();
        settle();
        write_port(16'hffff);
        run_random();
        settle();
        write_port(16'($urandom));
        run_random();
        settle();

        if (sb.errors == 0) begin
            $display("PASS control_frame_classifier_top");
        end else begin
            $display("FAIL control_frame_classifier_top");
        end
        $finish;
    end

endmodule

FILE: sim.f
sv/cfc_pkg.sv
sv/control_frame_classifier_top.sv
sim/tb_control_frame_classifier_top.sv
